### sv/cwc_pkg.sv
// Types and constants shared by the calibrated wall clock and its checker.
package cwc_pkg;

    typedef enum logic [1:0] {
        KIND_QUERY = 2'd0,
        KIND_SET   = 2'd1,
        KIND_SKEW  = 2'd2,
        KIND_BEGIN = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        SRC_UNSET     = 2'd0,
        SRC_ESTIMATED = 2'd1,
        SRC_USER      = 2'd2,
        SRC_NETWORK   = 2'd3
    } source_t;

    // Number of defined calibration sources; a source code must lie below it.
    localparam logic [4:0] SOURCE_COUNT = 5'd4;

    // Register indexes (byte address / 4).
    localparam logic [1:0] REG_SANE_MIN = 2'd0;
    localparam logic [1:0] REG_ROLLBACK = 2'd1;
    localparam logic [1:0] REG_RTC_EN   = 2'd2;

    localparam logic [31:0] SANE_MIN_RESET = 32'd1483228800;
    localparam logic [31:0] ROLLBACK_RESET = 32'd600;
    localparam logic [31:0] SEC_MAX        = 32'hFFFF_FFFF;

    // Skew stays within +/- (2^32 - 1).
    localparam logic signed [36:0] SKEW_HI = 37'sh0_FFFF_FFFF;
    localparam logic signed [36:0] SKEW_LO = -37'sh0_FFFF_FFFF;

    // ceil(2^30 / 125): exact quotient for any 23-bit dividend.
    localparam logic [23:0] RECIP_125 = 24'd8589935;
    localparam logic [22:0] DIV_125   = 23'd125;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 72;

    typedef struct packed {
        logic        pend;      // set whose rollback check waits for the divider
        logic        acc;       // set taken
        logic        rtc_ok;    // RTC reading trusted and sane
        logic [31:0] rtc;
        logic [31:0] epoch;
        logic [1:0]  src;
        logic [1:0]  cal;
        logic [33:0] skew;      // two's complement
        logic [31:0] base_sec;
        logic [63:0] up;
        logic [63:0] base_up;
    } item_t;

endpackage

### sv/calibrated_wall_clock.sv
// Calibrated wall clock: millisecond counter extension, epoch tracking and skew.
//
// Input stream: s_tuser carries the operation (query, set epoch, add skew,
// begin), s_tdata the millisecond sample, RTC reading, epoch, source and skew.
// Every transfer in yields exactly one transfer out on the m_ channel with the
// current epoch seconds (skew applied, clamped), calibration state and the
// RTC write request of an accepted set.
// One item is taken per cycle while the receiver keeps up; a set epoch that
// needs its rollback check against the computed clock (calibrated, non-user
// source, RTC not trusted) holds the input until the divider pipeline resolves
// it and, if the check passes, writes the new base.
// Elapsed milliseconds are divided by 1000 as a shift by 3 and two
// reciprocal multiplies by 1/125, each in its own stage.
// Reset (aresetn low, synchronous) empties the pipeline, clears the clock
// state and loads the register defaults. When the receiver stalls, the whole
// pipeline holds; an empty input register takes one more item, then s_tready drops.
// Registers over APB: 0x0 sane epoch minimum, 0x4 rollback tolerance,
// 0x8 RTC enable. Write them only while the block is idle.
module calibrated_wall_clock (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // ms_sample[31:0], rtc_seconds[63:32], epoch[95:64], source[97:96],
    // skew_delta[133:98], zero pad[135:134]
    input  logic [cwc_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // now_seconds[31:0], cal_source[33:32], accepted[34], rtc_write[35],
    // rtc_value[67:36], zero pad[71:68]
    output logic [cwc_pkg::M_TDATA_W-1:0]  m_tdata,
    // time_valid[0]
    output logic [0:0]                     m_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    // ---------------- configuration registers ----------------
    logic [31:0] sane_min_reg;
    logic [31:0] rollback_reg;
    logic        rtc_en_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sane_min_reg <= cwc_pkg::SANE_MIN_RESET;
            rollback_reg <= cwc_pkg::ROLLBACK_RESET;
            rtc_en_reg   <= 1'b1;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                cwc_pkg::REG_SANE_MIN: sane_min_reg <= pwdata;
                cwc_pkg::REG_ROLLBACK: rollback_reg <= pwdata;
                cwc_pkg::REG_RTC_EN:   rtc_en_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            cwc_pkg::REG_SANE_MIN: prdata = sane_min_reg;
            cwc_pkg::REG_ROLLBACK: prdata = rollback_reg;
            cwc_pkg::REG_RTC_EN:   prdata = {31'd0, rtc_en_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // ---------------- input register ----------------
    logic         s0_vld_reg;
    logic [133:0] s0_data_reg;
    logic [1:0]   s0_kind_reg;

    // ---------------- clock state ----------------
    logic [31:0] last_reg;
    logic [31:0] wrap_reg;
    logic [31:0] base_sec_reg;
    logic [63:0] base_up_reg;
    logic [33:0] skew_reg;
    logic [1:0]  cal_reg;
    logic        started_reg;
    logic        pend_reg;

    // ---------------- pipeline ----------------
    logic [7:1]       vld_reg;
    cwc_pkg::item_t   pipe_reg [1:7];
    logic             advance;
    logic             front_go;
    logic             wb_go;

    // Whole pipeline moves together; the output register parts the sides.
    logic        m_vld_reg;
    logic [67:0] m_data_reg;
    logic        m_time_valid_reg;

    assign advance  = !m_vld_reg || m_tready;
    // Hold new work while a set is still waiting on its rollback check.
    assign front_go = s0_vld_reg && !pend_reg && advance;
    assign s_tready = !s0_vld_reg || front_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
        end else if (s_tready) begin
            s0_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s0_data_reg <= s_tdata[133:0];
            s0_kind_reg <= s_tuser;
        end
    end

    // ---------------- front: sample, state update ----------------
    logic [31:0]        in_ms;
    logic [31:0]        in_rtc;
    logic [31:0]        in_ep;
    logic [1:0]         in_src;
    logic signed [35:0] in_skew;

    assign in_ms   = s0_data_reg[31:0];
    assign in_rtc  = s0_data_reg[63:32];
    assign in_ep   = s0_data_reg[95:64];
    assign in_src  = s0_data_reg[97:96];
    assign in_skew = $signed(s0_data_reg[133:98]);

    logic               restart;
    logic [31:0]        last_eff;
    logic [31:0]        wrap_eff;
    logic [1:0]         cal_eff;
    logic [33:0]        skew_eff;
    logic [31:0]        wrap_new;
    logic [63:0]        up;
    logic               rtc_ok;
    logic               set_ok;
    logic               check;
    logic [31:0]        rtc_gap;
    logic               rtc_fail;
    logic signed [36:0] skew_sum;
    logic signed [36:0] skew_sat;
    logic [1:0]         cal_new;
    logic [33:0]        skew_new;
    logic [31:0]        base_sec_new;
    logic [63:0]        base_up_new;
    logic               started_new;
    logic               pend;
    logic               acc;
    cwc_pkg::item_t     front_item;

    always_comb begin
        // A begin on a fresh clock clears the tracking state before sampling.
        restart  = (s0_kind_reg == cwc_pkg::KIND_BEGIN) && !started_reg;
        last_eff = restart ? 32'd0 : last_reg;
        wrap_eff = restart ? 32'd0 : wrap_reg;
        cal_eff  = restart ? cwc_pkg::SRC_UNSET : cal_reg;
        skew_eff = restart ? 34'd0 : skew_reg;

        // A sample below the previous one means exactly one counter wrap.
        wrap_new = (in_ms < last_eff) ? wrap_eff + 32'd1 : wrap_eff;
        up       = {wrap_new, in_ms};

        rtc_ok = rtc_en_reg && (in_rtc != 32'd0) && (in_rtc >= sane_min_reg);

        set_ok = (in_src != cwc_pkg::SRC_UNSET)
              && ({3'd0, in_src} < cwc_pkg::SOURCE_COUNT)
              && (in_ep >= sane_min_reg);
        check  = set_ok && (cal_eff != cwc_pkg::SRC_UNSET) && (in_src != cwc_pkg::SRC_USER);
        // With a trusted RTC the current clock is the reading itself.
        rtc_gap  = in_rtc - in_ep;
        rtc_fail = (in_ep < in_rtc) && (rtc_gap > rollback_reg);

        skew_sum = $signed({{3{skew_eff[33]}}, skew_eff}) + $signed({in_skew[35], in_skew});
        if (skew_sum > cwc_pkg::SKEW_HI) begin
            skew_sat = cwc_pkg::SKEW_HI;
        end else if (skew_sum < cwc_pkg::SKEW_LO) begin
            skew_sat = cwc_pkg::SKEW_LO;
        end else begin
            skew_sat = skew_sum;
        end

        cal_new      = cal_eff;
        skew_new     = skew_eff;
        base_sec_new = base_sec_reg;
        base_up_new  = base_up_reg;
        started_new  = started_reg;
        pend         = 1'b0;
        acc          = 1'b0;

        case (s0_kind_reg)
            cwc_pkg::KIND_QUERY: begin
                if (cal_eff == cwc_pkg::SRC_UNSET && rtc_ok) begin
                    cal_new = cwc_pkg::SRC_ESTIMATED;
                end
            end
            cwc_pkg::KIND_SET: begin
                if (check && !rtc_ok) begin
                    pend = 1'b1;
                end else if (set_ok && !(check && rtc_fail)) begin
                    acc          = 1'b1;
                    base_sec_new = in_ep;
                    base_up_new  = up;
                    cal_new      = in_src;
                end
            end
            cwc_pkg::KIND_SKEW: begin
                skew_new = skew_sat[33:0];
            end
            cwc_pkg::KIND_BEGIN: begin
                if (restart) begin
                    base_sec_new = (in_ep >= sane_min_reg) ? in_ep : 32'd0;
                    base_up_new  = up;
                    started_new  = 1'b1;
                end
                if (cal_eff == cwc_pkg::SRC_UNSET && rtc_ok) begin
                    cal_new = cwc_pkg::SRC_ESTIMATED;
                end
            end
            default: ;
        endcase

        front_item.pend     = pend;
        front_item.acc      = acc;
        front_item.rtc_ok   = rtc_ok;
        front_item.rtc      = in_rtc;
        front_item.epoch    = in_ep;
        front_item.src      = in_src;
        front_item.cal      = cal_new;
        front_item.skew     = skew_new;
        front_item.base_sec = base_sec_new;
        front_item.up       = up;
        front_item.base_up  = base_up_new;
    end

    // ---------------- stage 6: late rollback decision ----------------
    logic [31:0]    base6_reg;
    logic [31:0]    cur_gap;
    logic           cur_fail;
    logic           s6_take;
    cwc_pkg::item_t s6_item;
    logic [31:0]    val6;

    always_comb begin
        cur_gap  = base6_reg - pipe_reg[6].epoch;
        cur_fail = (pipe_reg[6].epoch < base6_reg) && (cur_gap > rollback_reg);
        s6_take  = pipe_reg[6].pend && !cur_fail;
        s6_item  = pipe_reg[6];
        val6     = base6_reg;
        if (s6_take) begin
            s6_item.acc = 1'b1;
            s6_item.cal = pipe_reg[6].src;
            val6        = pipe_reg[6].epoch;
        end
    end

    assign wb_go = advance && vld_reg[6] && pipe_reg[6].pend;

    // Advance the clock state at the front; write back a late-decided set.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg     <= 32'd0;
            wrap_reg     <= 32'd0;
            base_sec_reg <= 32'd0;
            base_up_reg  <= 64'd0;
            skew_reg     <= 34'd0;
            cal_reg      <= cwc_pkg::SRC_UNSET;
            started_reg  <= 1'b0;
            pend_reg     <= 1'b0;
        end else if (front_go) begin
            last_reg     <= in_ms;
            wrap_reg     <= wrap_new;
            base_sec_reg <= base_sec_new;
            base_up_reg  <= base_up_new;
            skew_reg     <= skew_new;
            cal_reg      <= cal_new;
            started_reg  <= started_new;
            pend_reg     <= pend;
        end else if (wb_go) begin
            pend_reg <= 1'b0;
            if (s6_take) begin
                base_sec_reg <= pipe_reg[6].epoch;
                base_up_reg  <= pipe_reg[6].up;
                cal_reg      <= pipe_reg[6].src;
            end
        end
    end

    // ---------------- divider stages ----------------
    // elapsed / 1000 = (elapsed >> 3) / 125, split as a high and a low part.
    logic [63:0] elapsed;
    logic [22:0] hi2_reg;
    logic [15:0] lo2_reg;
    logic        sat2_reg;
    logic [46:0] p1_3_reg;
    logic [22:0] hi3_reg;
    logic [15:0] lo3_reg;
    logic        sat3_reg;
    logic [16:0] q1;
    logic [22:0] r1_full;
    logic [16:0] q1_4_reg;
    logic [22:0] y4_reg;
    logic        sat4_reg;
    logic [46:0] p2_5_reg;
    logic [16:0] q1_5_reg;
    logic        sat5_reg;
    logic [15:0] q2;
    logic [33:0] base_sum;
    logic [31:0] base5;
    logic [31:0] val7_reg;

    assign elapsed = pipe_reg[1].up - pipe_reg[1].base_up;
    assign q1      = p1_3_reg[46:30];
    assign r1_full = hi3_reg - {6'd0, q1} * cwc_pkg::DIV_125;
    assign q2      = p2_5_reg[45:30];
    assign base_sum = {2'd0, pipe_reg[5].base_sec} + {1'b0, q1_5_reg, q2};

    always_comb begin
        if (pipe_reg[5].rtc_ok) begin
            base5 = pipe_reg[5].rtc;
        end else if (sat5_reg || base_sum[33:32] != 2'd0) begin
            base5 = cwc_pkg::SEC_MAX;
        end else begin
            base5 = base_sum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= {vld_reg[6:1], front_go};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pipe_reg[1] <= front_item;
            pipe_reg[2] <= pipe_reg[1];
            pipe_reg[3] <= pipe_reg[2];
            pipe_reg[4] <= pipe_reg[3];
            pipe_reg[5] <= pipe_reg[4];
            pipe_reg[6] <= pipe_reg[5];
            pipe_reg[7] <= s6_item;

            // Anything at or past 2^42 ms saturates the 32-bit epoch anyway.
            sat2_reg <= elapsed[63:42] != 22'd0;
            hi2_reg  <= elapsed[41:19];
            lo2_reg  <= elapsed[18:3];

            p1_3_reg <= {24'd0, hi2_reg} * {23'd0, cwc_pkg::RECIP_125};
            hi3_reg  <= hi2_reg;
            lo3_reg  <= lo2_reg;
            sat3_reg <= sat2_reg;

            q1_4_reg <= q1;
            y4_reg   <= {r1_full[6:0], lo3_reg};
            sat4_reg <= sat3_reg;

            p2_5_reg <= {24'd0, y4_reg} * {23'd0, cwc_pkg::RECIP_125};
            q1_5_reg <= q1_4_reg;
            sat5_reg <= sat4_reg;

            base6_reg <= base5;
            val7_reg  <= val6;
        end
    end

    // ---------------- stage 7: skew and clamp into output register ----------------
    logic signed [34:0] now_sum;
    logic [31:0]        now_sec;

    always_comb begin
        now_sum = $signed({3'd0, val7_reg}) + $signed({pipe_reg[7].skew[33], pipe_reg[7].skew});
        if (now_sum[34]) begin
            now_sec = 32'd0;
        end else if (now_sum[33:32] != 2'd0) begin
            now_sec = cwc_pkg::SEC_MAX;
        end else begin
            now_sec = now_sum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (advance) begin
            m_vld_reg <= vld_reg[7];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= {pipe_reg[7].acc ? pipe_reg[7].epoch : 32'd0,
                           pipe_reg[7].acc,
                           pipe_reg[7].acc,
                           pipe_reg[7].cal,
                           now_sec};
            m_time_valid_reg <= (pipe_reg[7].cal != cwc_pkg::SRC_UNSET) || pipe_reg[7].rtc_ok;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {4'd0, m_data_reg};
    assign m_tuser  = m_time_valid_reg;

endmodule

### sv/cwc_checker.sv
// Port-level checker for the calibrated wall clock, bound to the top level.
module cwc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cwc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                    m_tuser
);

    // Hold a stalled result transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // RTC write request goes with an accepted set only.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[35] == m_tdata[34])
        else $error("rtc_write differs from accepted");

    // No RTC value without a write.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[35] |-> m_tdata[67:36] == 32'd0)
        else $error("rtc_value set without rtc_write");

    // A calibrated clock always reports valid time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33:32] != cwc_pkg::SRC_UNSET |-> m_tuser[0])
        else $error("calibrated clock reported invalid");

endmodule

bind calibrated_wall_clock cwc_checker u_cwc_checker (.*);

### test/calibrated_wall_clock_tb.sv
// Self-checking testbench for the calibrated wall clock: directed corners plus random traffic.
module calibrated_wall_clock_tb;

    localparam int CYCLE_LIMIT = 600_000;

    // One expected m_ channel transfer.
    typedef struct packed {
        logic [31:0]      now;
        logic             valid;
        cwc_pkg::source_t cal;
        logic             acc;
        logic             rtc_wr;
        logic [31:0]      rtc_val;
    } clock_reading_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    // ms_sample[31:0], rtc_seconds[63:32], epoch[95:64], source[97:96],
    // skew_delta[133:98], zero pad[135:134]
    logic [cwc_pkg::S_TDATA_W-1:0] s_tdata;
    // kind[1:0]
    logic [1:0]                    s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    // now_seconds[31:0], cal_source[33:32], accepted[34], rtc_write[35],
    // rtc_value[67:36], zero pad[71:68]
    logic [cwc_pkg::M_TDATA_W-1:0] m_tdata;
    // time_valid[0]
    logic [0:0]                    m_tuser;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [3:0]                    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    // Register copies, kept in step with every APB write.
    logic [31:0] cfg_sane_min = cwc_pkg::SANE_MIN_RESET;
    logic [31:0] cfg_rollback = cwc_pkg::ROLLBACK_RESET;
    logic        cfg_rtc_en   = 1'b1;

    // Clock state as the block should hold it after reset.
    logic [31:0]      last_ms  = '0;
    logic [31:0]      wraps    = '0;
    logic [31:0]      base_sec = '0;
    logic [63:0]      base_up  = '0;
    longint           skew     = 0;
    cwc_pkg::source_t cal_st   = cwc_pkg::SRC_UNSET;
    bit               begun    = 1'b0;

    // Stimulus helpers: free-running ms counter and the last predicted clock.
    logic [31:0] ms_clock = '0;
    logic [31:0] last_now = '0;
    bit          sender_idle_on = 1'b1;

    clock_reading_t pending_readings[$];

    int mismatches      = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int sets_taken      = 0;
    int wraps_seen      = 0;
    int cycle_count     = 0;

    calibrated_wall_clock dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog: end the run with an error once the cycle count passes CYCLE_LIMIT.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // A reading counts only when trust is enabled, nonzero and not below the minimum.
    function automatic bit rtc_trusted(logic [31:0] rtc);
        return cfg_rtc_en && rtc != 32'd0 && rtc >= cfg_sane_min;
    endfunction

    // Base epoch: trusted RTC, else stored base plus elapsed seconds, saturated.
    function automatic logic [31:0] clock_base(logic [63:0] up, logic [31:0] rtc);
        logic [63:0] sum;
        if (rtc_trusted(rtc))
            return rtc;
        sum = {32'd0, base_sec} + (up - base_up) / 64'd1000;
        return (sum > {32'd0, cwc_pkg::SEC_MAX}) ? cwc_pkg::SEC_MAX : sum[31:0];
    endfunction

    function automatic void adopt_rtc(logic [31:0] rtc);
        if (cal_st == cwc_pkg::SRC_UNSET && rtc_trusted(rtc))
            cal_st = cwc_pkg::SRC_ESTIMATED;
    endfunction

    // Apply one operation to the clock state and return the reading it yields.
    function automatic clock_reading_t advance_clock(cwc_pkg::kind_t op, logic [31:0] ms,
            logic [31:0] rtc, logic [31:0] ep, cwc_pkg::source_t src, logic [35:0] delta);
        clock_reading_t rd;
        logic [63:0]    up;
        logic [31:0]    cur;
        longint         sum;
        bit             ok;
        rd = '0;

        // The first begin drops whatever the counter extension, calibration and skew held.
        if (op == cwc_pkg::KIND_BEGIN && !begun) begin
            last_ms = '0;
            wraps   = '0;
            cal_st  = cwc_pkg::SRC_UNSET;
            skew    = 0;
        end

        // A sample below the previous one means exactly one wrap.
        if (ms < last_ms) begin
            wraps = wraps + 32'd1;
            wraps_seen++;
        end
        last_ms = ms;
        up = {wraps, ms};

        case (op)
            cwc_pkg::KIND_QUERY: adopt_rtc(rtc);
            cwc_pkg::KIND_SET: begin
                ok = src != cwc_pkg::SRC_UNSET && 5'(src) < cwc_pkg::SOURCE_COUNT
                     && ep >= cfg_sane_min;
                // Non-user sources may not pull a calibrated clock back too far.
                if (ok && cal_st != cwc_pkg::SRC_UNSET && src != cwc_pkg::SRC_USER) begin
                    cur = clock_base(up, rtc);
                    if (ep < cur && (cur - ep) > cfg_rollback)
                        ok = 1'b0;
                end
                if (ok) begin
                    base_sec = ep;
                    base_up  = up;
                    cal_st   = src;
                    rd.acc   = 1'b1;
                    sets_taken++;
                end
            end
            cwc_pkg::KIND_SKEW: begin
                sum = skew + longint'($signed(delta));
                if (sum > longint'(cwc_pkg::SKEW_HI))
                    sum = longint'(cwc_pkg::SKEW_HI);
                if (sum < longint'(cwc_pkg::SKEW_LO))
                    sum = longint'(cwc_pkg::SKEW_LO);
                skew = sum;
            end
            default: begin
                if (!begun) begin
                    base_sec = (ep >= cfg_sane_min) ? ep : 32'd0;
                    base_up  = up;
                    begun    = 1'b1;
                end
                adopt_rtc(rtc);
            end
        endcase

        // Report base plus skew, clamped to the unsigned 32-bit range.
        sum = longint'({32'd0, clock_base(up, rtc)}) + skew;
        if (sum < 0)
            sum = 0;
        if (sum > longint'({32'd0, cwc_pkg::SEC_MAX}))
            sum = longint'({32'd0, cwc_pkg::SEC_MAX});
        rd.now     = sum[31:0];
        rd.valid   = cal_st != cwc_pkg::SRC_UNSET || rtc_trusted(rtc);
        rd.cal     = cal_st;
        rd.rtc_wr  = rd.acc;
        rd.rtc_val = rd.acc ? ep : 32'd0;
        last_now   = rd.now;
        return rd;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random backpressure and the checker
    // ------------------------------------------------------------------

    // Mostly short ready and stall spells, a few long stalls, rarely a long open stretch.
    initial begin
        int r;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else if (r < 88) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else if (r < 96) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(4, 30)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(100, 300)) @(posedge aclk);
            end
        end
    end

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each result transfer against the oldest expectation.
    always @(posedge aclk) begin
        clock_reading_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_readings.size() == 0) begin
                $error("unexpected result transfer: m_tdata 0x%0h", m_tdata);
                mismatches++;
            end else begin
                want = pending_readings.pop_front();
                compare_field("now_seconds", want.now, m_tdata[31:0]);
                compare_field("cal_source", want.cal, m_tdata[33:32]);
                compare_field("accepted", want.acc, m_tdata[34]);
                compare_field("rtc_write", want.rtc_wr, m_tdata[35]);
                compare_field("rtc_value", want.rtc_val, m_tdata[67:36]);
                compare_field("time_valid", want.valid, m_tuser[0]);
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Sender gaps: mostly none or short, a few long; none at all when idling is off.
    function automatic int idle_cycles();
        int r;
        if (!sender_idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // Present one operation, hold it until the transfer, then record its reading.
    // Valid stays high on return so a back-to-back item never toggles it.
    task automatic send_item(cwc_pkg::kind_t op, logic [31:0] ms, logic [31:0] rtc,
                             logic [31:0] ep, cwc_pkg::source_t src, logic [35:0] delta);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, delta, src, ep, rtc, ms};
        do @(posedge aclk); while (s_tready !== 1'b1);
        pending_readings.push_back(advance_clock(op, ms, rtc, ep, src, delta));
        items_sent++;
    endtask

    // Drop valid and hold off until every expected reading has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_readings.size() != 0);
    endtask

    // APB write, then read the register back; the bus is then left idle.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            cwc_pkg::REG_SANE_MIN: cfg_sane_min = value;
            cwc_pkg::REG_ROLLBACK: cfg_rollback = value;
            default:               cfg_rtc_en   = value[0];
        endcase
        want = (idx == cwc_pkg::REG_RTC_EN) ? {31'd0, value[0]} : value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        compare_field("prdata", want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Registers change only with the block idle.
    task automatic set_config(logic [31:0] sane_min, logic [31:0] rollback, logic rtc_en);
        drain_results();
        write_reg(cwc_pkg::REG_SANE_MIN, sane_min);
        write_reg(cwc_pkg::REG_ROLLBACK, rollback);
        write_reg(cwc_pkg::REG_RTC_EN, {31'd0, rtc_en});
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Traffic before and around the first begin: counter wraps, an early set and skew
    // that the first begin throws away, a second begin that samples and adopts the RTC.
    task automatic test_cold_start();
        send_item(cwc_pkg::KIND_QUERY, 32'd0, 32'd0, 32'd0, cwc_pkg::SRC_UNSET, 36'd0);
        send_item(cwc_pkg::KIND_SKEW, 32'd100, 32'd0, 32'd0, cwc_pkg::SRC_UNSET, 36'd5);
        send_item(cwc_pkg::KIND_QUERY, 32'd50, 32'd0, 32'd0, cwc_pkg::SRC_UNSET, 36'd0);
        send_item(cwc_pkg::KIND_SET, 32'd60, 32'd0, cwc_pkg::SANE_MIN_RESET + 32'd1000,
                  cwc_pkg::SRC_USER, 36'd0);
        // Seed below the minimum leaves the base at zero.
        send_item(cwc_pkg::KIND_BEGIN, 32'd7000, 32'd0, cwc_pkg::SANE_MIN_RESET - 32'd1,
                  cwc_pkg::SRC_UNSET, 36'd0);
        send_item(cwc_pkg::KIND_BEGIN, 32'd9000, cwc_pkg::SANE_MIN_RESET + 32'd100,
                  cwc_pkg::SANE_MIN_RESET + 32'd5, cwc_pkg::SRC_UNSET, 36'd0);
        send_item(cwc_pkg::KIND_QUERY, 32'hFFFF_FFFF, 32'd0, 32'd0, cwc_pkg::SRC_UNSET, 36'd0);
        send_item(cwc_pkg::KIND_QUERY, 32'd0, cwc_pkg::SEC_MAX, 32'd0, cwc_pkg::SRC_UNSET,
                  36'd0);
    endtask

    // Source, minimum and rollback rules, against the computed clock and a trusted RTC.
    task automatic test_set_rules();
        logic [31:0] ep;
        ep = cwc_pkg::SANE_MIN_RESET + 32'd5000;
        send_item(cwc_pkg::KIND_SET, 32'd1000, 32'd0, cwc_pkg::SANE_MIN_RESET + 32'd10,
                  cwc_pkg::SRC_UNSET, 36'd0);
        send_item(cwc_pkg::KIND_SET, 32'd1000, 32'd0, cwc_pkg::SANE_MIN_RESET - 32'd1,
                  cwc_pkg::SRC_NETWORK, 36'd0);
        send_item(cwc_pkg::KIND_SET, 32'd2000, 32'd0, cwc_pkg::SEC_MAX,
                  cwc_pkg::SRC_NETWORK, 36'd0);
        // Same sample, so the computed clock equals the base just set.
        send_item(cwc_pkg::KIND_SET, 32'd2000, 32'd0, cwc_pkg::SEC_MAX - 32'd600,
                  cwc_pkg::SRC_ESTIMATED, 36'd0);
        send_item(cwc_pkg::KIND_SET, 32'd2000, 32'd0, cwc_pkg::SEC_MAX - 32'd1201,
                  cwc_pkg::SRC_NETWORK, 36'd0);
        send_item(cwc_pkg::KIND_SET, 32'd2000, 32'd0, cwc_pkg::SEC_MAX - 32'd1201,
                  cwc_pkg::SRC_USER, 36'd0);
        send_item(cwc_pkg::KIND_SET, 32'd2500, ep + 32'd601, ep, cwc_pkg::SRC_NETWORK, 36'd0);
        send_item(cwc_pkg::KIND_SET, 32'd2500, ep + 32'd600, ep, cwc_pkg::SRC_NETWORK, 36'd0);
    endtask

    // Skew saturation both ways and the clamp of the reported time at both ends.
    task automatic test_skew_limits();
        send_item(cwc_pkg::KIND_SKEW, 32'd3000, 32'd0, 32'd0, cwc_pkg::SRC_UNSET,
                  36'h7_FFFF_FFFF);
        send_item(cwc_pkg::KIND_SKEW, 32'd3000, 32'd0, 32'd0, cwc_pkg::SRC_UNSET,
                  36'h8_0000_0000);
        send_item(cwc_pkg::KIND_SKEW, 32'd3000, 32'd0, 32'd0, cwc_pkg::SRC_UNSET,
                  36'h8_0000_0000);
        send_item(cwc_pkg::KIND_SKEW, 32'd3000, 32'd0, 32'd0, cwc_pkg::SRC_UNSET,
                  36'h1_0000_0000);
        // RTC exactly at the minimum is trusted.
        send_item(cwc_pkg::KIND_QUERY, 32'd4000, cwc_pkg::SANE_MIN_RESET, 32'd0,
                  cwc_pkg::SRC_UNSET, 36'd0);
    endtask

    // Register extremes: RTC trust off, zero minimum and tolerance, all-ones both.
    task automatic test_register_extremes();
        set_config(cwc_pkg::SANE_MIN_RESET, cwc_pkg::ROLLBACK_RESET, 1'b0);
        send_item(cwc_pkg::KIND_QUERY, 32'd5000, cwc_pkg::SEC_MAX, 32'd0,
                  cwc_pkg::SRC_UNSET, 36'd0);
        set_config(32'd0, 32'd0, 1'b1);
        send_item(cwc_pkg::KIND_QUERY, 32'd6000, 32'd0, 32'd0, cwc_pkg::SRC_UNSET, 36'd0);
        send_item(cwc_pkg::KIND_SET, 32'd6000, 32'd0, 32'd0, cwc_pkg::SRC_NETWORK, 36'd0);
        send_item(cwc_pkg::KIND_SET, 32'd6000, 32'd0, 32'd0, cwc_pkg::SRC_USER, 36'd0);
        set_config(cwc_pkg::SEC_MAX, cwc_pkg::SEC_MAX, 1'b1);
        send_item(cwc_pkg::KIND_QUERY, 32'd7000, cwc_pkg::SEC_MAX, 32'd0,
                  cwc_pkg::SRC_UNSET, 36'd0);
        send_item(cwc_pkg::KIND_SET, 32'd7000, 32'd0, cwc_pkg::SEC_MAX - 32'd1,
                  cwc_pkg::SRC_NETWORK, 36'd0);
        send_item(cwc_pkg::KIND_SET, 32'd7000, 32'd0, cwc_pkg::SEC_MAX,
                  cwc_pkg::SRC_NETWORK, 36'd0);
    endtask

    // Advance the ms counter: mostly small steps, sometimes a step back (one wrap),
    // a big jump or a fresh random value.
    function automatic logic [31:0] next_ms();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            ms_clock = $urandom;
        else if (r < 10)
            ms_clock = ms_clock - $urandom_range(1, 5000);
        else if (r < 15)
            ms_clock = ms_clock + $urandom_range(0, 32'h7FFF_FFFF);
        else
            ms_clock = ms_clock + $urandom_range(0, 4000);
        return ms_clock;
    endfunction

    // One random operation; epochs and RTC readings cluster around the current
    // clock and the minimum so the rollback and trust edges are hit often.
    task automatic send_random_item();
        int               r;
        int unsigned      span;
        cwc_pkg::kind_t   op;
        logic [31:0]      rtc;
        logic [31:0]      ep;
        cwc_pkg::source_t src;
        logic [35:0]      delta;

        r = $urandom_range(0, 99);
        op = (r < 35) ? cwc_pkg::KIND_QUERY :
             (r < 70) ? cwc_pkg::KIND_SET :
             (r < 85) ? cwc_pkg::KIND_SKEW : cwc_pkg::KIND_BEGIN;

        r = $urandom_range(0, 99);
        if (r < 30)
            rtc = 32'd0;
        else if (r < 55)
            rtc = $urandom;
        else if (r < 80)
            rtc = cfg_sane_min + $urandom_range(0, 4) - 32'd2;
        else
            rtc = last_now + $urandom_range(0, 2000) - 32'd1000;

        span = (cfg_rollback > 100000) ? 100000 : cfg_rollback + 50;
        r = $urandom_range(0, 99);
        if (r < 50)
            ep = last_now + $urandom_range(0, 2 * span) - span;
        else if (r < 65)
            ep = cfg_sane_min + $urandom_range(0, 4) - 32'd2;
        else if (r < 90)
            ep = $urandom;
        else
            ep = $urandom_range(0, 1) ? cwc_pkg::SEC_MAX : 32'd0;

        src = ($urandom_range(0, 9) == 0) ? cwc_pkg::SRC_UNSET
                                          : cwc_pkg::source_t'($urandom_range(1, 3));

        r = $urandom_range(0, 99);
        if (r < 60)
            delta = 36'($urandom_range(0, 20000)) - 36'd10000;
        else if (r < 85)
            delta = 36'({$urandom, $urandom});
        else begin
            case ($urandom_range(0, 3))
                0:       delta = 36'h7_FFFF_FFFF;
                1:       delta = 36'h8_0000_0000;
                2:       delta = 36'h1_0000_0000;
                default: delta = 36'hF_0000_0000;
            endcase
        end

        send_item(op, next_ms(), rtc, ep, src, delta);
    endtask

    // Five register settings, one of them with the sender never idling.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       set_config(cwc_pkg::SANE_MIN_RESET, cwc_pkg::ROLLBACK_RESET, 1'b1);
                1:       set_config(32'd0, 32'd0, 1'b1);
                2:       set_config(cwc_pkg::SEC_MAX, cwc_pkg::SEC_MAX, 1'b0);
                3:       set_config($urandom, $urandom_range(0, 5000), 1'b0);
                default: set_config(cwc_pkg::SANE_MIN_RESET, $urandom_range(0, 100000), 1'b1);
            endcase
            sender_idle_on = (phase != 1);
            for (int n = 0; n < 210; n++) begin
                // Now and then hold the sender until everything has drained.
                if ($urandom_range(0, 199) == 0)
                    drain_results();
                send_random_item();
            end
        end
        sender_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= cwc_pkg::KIND_QUERY;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_cold_start();
        test_set_rules();
        test_skew_limits();
        test_register_extremes();
        test_random_traffic();

        // Let the pipeline empty, then wait for any stray transfers.
        drain_results();
        repeat (20) @(posedge aclk);

        $display("Covered %0d operations, %0d readings checked, %0d sets taken, %0d ms wraps.",
                 items_sent, results_checked, sets_taken, wraps_seen);
        $display("Swept minimum and rollback tolerance from 0 to all ones, RTC trust on and off.");
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
